// ----- src/fraction_reducer_assert.svh -----
// ----------------------------------------------------------------------------
// fraction_reducer_assert.svh
// Assertion macros for the fraction reducer. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_ASSERT_SVH
`define FRACTION_REDUCER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion, held off while reset is asserted
`define FR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with an implication from a trigger
`define FR_ASSERT_IMPL(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

`else

`define FR_ASSERT(lbl, prop, msg)
`define FR_ASSERT_IMPL(lbl, trig, prop, msg)

`endif

`endif

// ----- src/frac_red_pkg.sv -----
// ----------------------------------------------------------------------------
// frac_red_pkg
// Shared types for the fraction reducer.
// ----------------------------------------------------------------------------
package frac_red_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWOS,
        ST_GCD,
        ST_CHECK,
        ST_DIV_N,
        ST_DIV_D,
        ST_DONE
    } state_t;

endpackage

// ----- src/fraction_reducer.sv -----
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a positive signed fraction to lowest terms with a shared subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   Drive numerator/denominator and pulse start while busy is low; the beat is
//   taken at that edge and busy rises on the next cycle. One result beat
//   follows: done is high for exactly one cycle with reduced_numerator,
//   reduced_denominator and was_reduced valid. The receiver cannot stall; the
//   result must be captured in that cycle.
//   If either operand is zero or negative the pair comes back unchanged with
//   was_reduced low, and done is high in the cycle right after the start beat.
//   Otherwise common factors of two are stripped first, then a binary gcd
//   runs with one shift, subtract or swap per cycle. A gcd of one ends there:
//   done follows through the check state. Else numerator and denominator are
//   each divided by the gcd in a restoring divider, one quotient bit per cycle,
//   numerator first and then denominator, and done follows the last quotient
//   bit. The next beat can be taken in the cycle after done. Reset returns the
//   sequencer to idle; no state is kept.
// ----------------------------------------------------------------------------
`include "fraction_reducer_assert.svh"

module fraction_reducer
    import frac_red_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] numerator,
    input  logic signed [VALUE_WIDTH-1:0] denominator,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] reduced_numerator,
    output logic signed [VALUE_WIDTH-1:0] reduced_denominator,
    output logic                          was_reduced
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [W-1:0]     a_reg, a_next;      // gcd operand, later the gcd
    logic [W-1:0]     b_reg, b_next;      // gcd operand
    logic [CNT_W-1:0] k_reg, k_next;      // shared power of two
    logic [W-1:0]     n_reg, n_next;      // numerator, then quotient
    logic [W-1:0]     d_reg, d_next;      // denominator, then quotient
    logic [W-1:0]     rem_reg, rem_next;  // division remainder
    logic [CNT_W-1:0] cnt_reg, cnt_next;  // division bit count
    logic             flag_reg, flag_next;

    logic [W-1:0]     op_x, op_y;
    logic [W:0]       diff;
    logic             n_pos, d_pos;
    logic [W-1:0]     q_sel;
    logic [W-1:0]     q_shift;
    logic [W-1:0]     rem_shift;

    // Operand checks on the incoming beat
    assign n_pos = (numerator != '0) && !numerator[W-1];
    assign d_pos = (denominator != '0) && !denominator[W-1];

    // Dividend under division
    assign q_sel = (state_reg == ST_DIV_D) ? d_reg : n_reg;

    // Shared subtractor: a - b during gcd, trial subtract during division
    always_comb
    begin
        if (state_reg == ST_DIV_N || state_reg == ST_DIV_D)
        begin
            op_x = {rem_reg[W-2:0], q_sel[W-1]};
            op_y = a_reg;
        end
        else
        begin
            op_x = a_reg;
            op_y = b_reg;
        end
        diff = {1'b0, op_x} - {1'b0, op_y};
    end

    // One restoring step
    always_comb
    begin
        if (!diff[W])
        begin
            rem_shift = diff[W-1:0];
            q_shift   = {q_sel[W-2:0], 1'b1};
        end
        else
        begin
            rem_shift = op_x;
            q_shift   = {q_sel[W-2:0], 1'b0};
        end
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        flag_reg <= flag_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        flag_next  = flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next    = numerator;
                    d_next    = denominator;
                    a_next    = numerator;
                    b_next    = denominator;
                    k_next    = '0;
                    flag_next = 1'b0;
                    state_next = (n_pos && d_pos) ? ST_TWOS : ST_DONE;
                end
            end
            ST_TWOS:
            begin
                // strip common factors of two
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (diff == '0)
                begin
                    a_next     = a_reg << k_reg;
                    state_next = ST_CHECK;
                end
                else if (diff[W])
                begin
                    // a < b: swap so the next subtract is positive
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    a_next = diff[W-1:0];
                end
            end
            ST_CHECK:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (a_reg == W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    flag_next  = 1'b1;
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N:
            begin
                rem_next = rem_shift;
                n_next   = q_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_D;
                end
            end
            ST_DIV_D:
            begin
                rem_next = rem_shift;
                d_next   = q_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    assign busy                = (state_reg != ST_IDLE);
    assign done                = (state_reg == ST_DONE);
    assign reduced_numerator   = n_reg;
    assign reduced_denominator = d_reg;
    assign was_reduced         = flag_reg;

    // Checks
    `FR_ASSERT_IMPL(a_start_busy, start && !busy, ##1 busy,
        "accepted beat did not raise busy")
    `FR_ASSERT_IMPL(a_done_pulse, done, ##1 !done, "done held longer than one cycle")
    `FR_ASSERT_IMPL(a_gcd_nonzero, state_reg == ST_GCD, a_reg != '0 && b_reg != '0,
        "zero gcd operand")
    `FR_ASSERT_IMPL(a_rem_bound, state_reg == ST_DIV_N || state_reg == ST_DIV_D,
        rem_reg < a_reg, "remainder not below divisor")
    `FR_ASSERT_IMPL(a_reduced_pos, done && was_reduced,
        !n_reg[W-1] && n_reg != '0 && !d_reg[W-1] && d_reg != '0,
        "reduced result not positive")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fraction_reducer. Fractions go in one beat at a
// time through start/busy. A local lowest-terms model predicts every done
// beat, which is compared field by field. Directed extremes and pass-through
// pairs come first. Random pairs follow, mostly built around a shared factor,
// with random gaps and noise on the idle inputs.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W               = 32;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int NUM_FACTORED    = 900;
    localparam int NUM_MIXED       = 850;
    localparam int MAX_REPORTS     = 10;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 16;
    localparam logic [W-1:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [W-1:0] MIN_NEG = 32'h8000_0000;

    // One expected result beat
    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic         reduced;
    } fraction_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] numerator = '0;
    logic [W-1:0] denominator = '0;
    logic         done;
    logic [W-1:0] reduced_numerator;
    logic [W-1:0] reduced_denominator;
    logic         was_reduced;

    fraction_t    expected_fractions[$];
    int           fractions_sent = 0;
    int           fractions_checked = 0;
    int           fractions_reduced = 0;
    int           mismatches = 0;
    int           stall_cycles = 0;
    bit           burst_mode = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    fraction_reducer #(
        .VALUE_WIDTH(W)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .numerator          (numerator),
        .denominator        (denominator),
        .done               (done),
        .reduced_numerator  (reduced_numerator),
        .reduced_denominator(reduced_denominator),
        .was_reduced        (was_reduced)
    );

    // Lowest terms by Euclid; anything not strictly positive passes through
    function automatic fraction_t reduce_fraction(input logic [W-1:0] n,
                                                  input logic [W-1:0] d);
        fraction_t    res;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] r;
        res = '{num: n, den: d, reduced: 1'b0};
        if (n != '0 && !n[W-1] && d != '0 && !d[W-1])
        begin
            a = n;
            b = d;
            while (b != '0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            if (a > 1)
            begin
                res.num     = n / a;
                res.den     = d / a;
                res.reduced = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Gap after a beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 60);
    endfunction

    // Idle cycles with start low and junk on the operand ports
    task automatic idle_gap(input int cycles);
        if (cycles == 0)
            return;
        start <= 1'b0;
        repeat (cycles)
        begin
            numerator   <= $urandom;
            denominator <= $urandom;
            @(posedge clk);
        end
    endtask

    // Present one fraction, hold start until busy is low again, log expectation
    task automatic send_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
        numerator   <= n;
        denominator <= d;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_fractions.push_back(reduce_fraction(n, d));
        fractions_sent++;
        idle_gap(pick_gap());
    endtask

    // ---- tests ----

    task automatic test_extremes();
        send_fraction(32'd1, 32'd1);
        send_fraction(MAX_POS, MAX_POS);
        send_fraction(MAX_POS, 32'd1);
        send_fraction(32'd1, MAX_POS);
        send_fraction(MAX_POS, MAX_POS - 1);
        send_fraction(32'h4000_0000, 32'h2000_0000);
        send_fraction(32'd12, 32'd18);
        send_fraction(32'd7, 32'd13);
        send_fraction(32'd100, 32'd25);
        send_fraction(32'd196608, 32'd327680);
    endtask

    task automatic test_pass_through();
        send_fraction(32'd0, 32'd5);
        send_fraction(32'd5, 32'd0);
        send_fraction(32'd0, 32'd0);
        send_fraction(MIN_NEG, 32'd6);
        send_fraction(32'd6, MIN_NEG);
        send_fraction(32'hffff_ffff, 32'hffff_ffff);
        send_fraction(MIN_NEG, MIN_NEG);
        send_fraction(-32'sd12, 32'd18);
        send_fraction(MAX_POS, MIN_NEG);
    endtask

    // Positive pairs sharing a factor of random size
    task automatic test_common_factors();
        logic [W-1:0] g;
        logic [W-1:0] lim;
        int           k;
        for (int i = 0; i < NUM_FACTORED; i++)
        begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            k   = $urandom_range(1, 30);
            g   = $urandom_range(2, 32'd1 << k);
            lim = MAX_POS / g;
            send_fraction(g * $urandom_range(1, lim), g * $urandom_range(1, lim));
        end
    endtask

    // Any bit pattern, with zero, negative, coprime and equal operands mixed in
    task automatic test_random_mixed();
        logic [W-1:0] n;
        logic [W-1:0] d;
        for (int i = 0; i < NUM_MIXED; i++)
        begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            n = $urandom;
            d = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3, 4:
                begin
                    n[W-1] = 1'b0;
                    d[W-1] = 1'b0;
                end
                5:
                begin
                    if ($urandom_range(0, 1))
                        n = '0;
                    else
                        d = '0;
                end
                6:
                begin
                    if ($urandom_range(0, 1))
                        n[W-1] = 1'b1;
                    else
                        d[W-1] = 1'b1;
                end
                7:
                begin
                    n = $urandom_range(1, 1000);
                    d = $urandom_range(1, 1000);
                end
                8:
                begin
                    n[W-1] = 1'b0;
                    d = n;
                end
                default:
                begin
                    n = ($urandom_range(1, 255) | 1) << $urandom_range(0, 23);
                    d = ($urandom_range(1, 255) | 1) << $urandom_range(0, 23);
                end
            endcase
            send_fraction(n, d);
        end
    endtask

    // ---- result checker ----
    always @(posedge clk)
    begin
        fraction_t exp;
        if (rst_n && done)
        begin
            if (expected_fractions.size() == 0)
            begin
                note_mismatch($sformatf("done beat with nothing pending: %0d/%0d",
                                        $signed(reduced_numerator),
                                        $signed(reduced_denominator)));
            end
            else
            begin
                exp = expected_fractions.pop_front();
                fractions_checked++;
                if (exp.reduced)
                    fractions_reduced++;
                if (reduced_numerator !== exp.num)
                    note_mismatch($sformatf("reduced_numerator exp %h got %h",
                                            exp.num, reduced_numerator));
                if (reduced_denominator !== exp.den)
                    note_mismatch($sformatf("reduced_denominator exp %h got %h",
                                            exp.den, reduced_denominator));
                if (was_reduced !== exp.reduced)
                    note_mismatch($sformatf("was_reduced exp %b got %b",
                                            exp.reduced, was_reduced));
            end
        end
    end

    // ---- watchdog: no beat in or out for too long ----
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d fractions pending", expected_fractions.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---- sequence ----
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_pass_through();
        test_common_factors();
        test_random_mixed();

        // drain
        idle_gap(1);
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d fractions, %0d reduced by a common factor",
                 fractions_checked, fractions_sent, fractions_reduced);
        $display("Covered full-range extremes, zero/negative pass-through, coprime pairs");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
